// ===== rtl/core/lcfs_pkg.sv =====
// ----------------------------------------------------------------------------
// lcfs_pkg
// Shared types and command codes of the LED cube frame scan controller.
// ----------------------------------------------------------------------------
package lcfs_pkg;

  localparam logic [3:0] FUNC_LED       = 4'd0;
  localparam logic [3:0] FUNC_ROW       = 4'd1;
  localparam logic [3:0] FUNC_COLUMN    = 4'd2;
  localparam logic [3:0] FUNC_PILLAR    = 4'd3;
  localparam logic [3:0] FUNC_FLOOR     = 4'd4;
  localparam logic [3:0] FUNC_ROW_WALL  = 4'd5;
  localparam logic [3:0] FUNC_COL_WALL  = 4'd6;
  localparam logic [3:0] FUNC_ALL       = 4'd7;
  localparam logic [3:0] FUNC_TICK      = 4'd8;
  localparam logic [3:0] FUNC_SCAN      = 4'd9;

  // sweep span per axis: 1 means the axis runs over the whole side
  typedef struct packed {
    logic span_r;
    logic span_c;
    logic span_f;
  } span_t;

  function automatic span_t func_span(input logic [3:0] func);
    span_t s;
    s = '0;
    unique case (func)
      FUNC_ROW:      s.span_c = 1'b1;
      FUNC_COLUMN:   s.span_r = 1'b1;
      FUNC_PILLAR:   s.span_f = 1'b1;
      FUNC_FLOOR:    begin s.span_r = 1'b1; s.span_c = 1'b1; end
      FUNC_ROW_WALL: begin s.span_c = 1'b1; s.span_f = 1'b1; end
      FUNC_COL_WALL: begin s.span_r = 1'b1; s.span_f = 1'b1; end
      FUNC_ALL:      begin s.span_r = 1'b1; s.span_c = 1'b1; s.span_f = 1'b1; end
      default:       s = '0;
    endcase
    return s;
  endfunction

endpackage

// ===== rtl/core/lcfs_store.sv =====
// ----------------------------------------------------------------------------
// lcfs_store
// Per-LED store: lit and never-expires bits in flops, deadlines in a memory.
// ----------------------------------------------------------------------------
module lcfs_store #(
  parameter int TIME_BITS = 32
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 wr_en,
  input  logic [8:0]           wr_addr,
  input  logic                 wr_lit,
  input  logic                 wr_never,
  input  logic [TIME_BITS-1:0] wr_time,
  input  logic                 clr_en,
  input  logic [8:0]           rd_addr,
  output logic                 rd_lit,
  output logic                 rd_never,
  output logic [TIME_BITS-1:0] rd_time
);

  logic [511:0]          lit_map;
  logic [511:0]          never_expires;
  logic [TIME_BITS-1:0]  expiry_time [512];

  always_ff @(posedge clk) begin
    if (rst) begin
      lit_map       <= '0;
      never_expires <= '1;
    end else if (wr_en) begin
      lit_map[wr_addr]       <= wr_lit;
      never_expires[wr_addr] <= wr_never;
    end else if (clr_en) begin
      lit_map[wr_addr] <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) expiry_time[wr_addr] <= wr_time;
    rd_time <= expiry_time[rd_addr];
  end

  always_ff @(posedge clk) begin
    rd_lit   <= lit_map[rd_addr];
    rd_never <= never_expires[rd_addr];
  end

endmodule

// ===== rtl/core/led_cube_frame_scan_controller.sv =====
// ----------------------------------------------------------------------------
// led_cube_frame_scan_controller
// Frame store and floor scanner for an LED cube with per-LED expiry.
// ----------------------------------------------------------------------------
// Input channel: func, row, column, floor, led_on, no_expiry, duration with
// valid/stall. Output channel: floor_pattern, floor_select, valid/stall; only
// a scan produces a result.
// A sequencer walks the LEDs through the store (one write port and
// one registered read port), one LED per cycle for a set command. Set
// commands write each LED touched (1 to SIDE^3); a tick advances the
// clock; a scan is accepted, then reads and compares-and-clears each LED of
// its floor in turn, and its result becomes valid after the last LED is checked.
// The block takes no new request while one is in progress.
// Reset clears all lit bits, marks every LED as never expiring and sets the
// clock to zero; no clearing pass is needed.
// A stalled result is held in the output register; the next request is
// accepted while it waits unless it is a scan, which waits for the register.
// ----------------------------------------------------------------------------
module led_cube_frame_scan_controller #(
  parameter int SIDE      = 8,
  parameter int TIME_BITS = 32
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [3:0]           func,
  input  logic [2:0]           row,
  input  logic [2:0]           column,
  input  logic [2:0]           floor,
  input  logic                 led_on,
  input  logic                 no_expiry,
  input  logic [31:0]          duration,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [63:0]          floor_pattern,
  output logic [7:0]           floor_select
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SET  = 2'd1;
  localparam logic [1:0] ST_RD   = 2'd2;
  localparam logic [1:0] ST_CHK  = 2'd3;
  localparam logic [2:0] LAST    = 3'(SIDE - 1);

  logic [1:0]           state;
  logic [TIME_BITS-1:0] now_ms;
  logic [2:0]           r, c, f;
  lcfs_pkg::span_t      span;
  logic                 on_q, forever_q;
  logic [TIME_BITS-1:0] deadline;
  logic [63:0]          pat;
  logic                 accept, last_cell, coord_ok, busy_out;
  logic                 rd_lit, rd_never, expired;
  logic [TIME_BITS-1:0] rd_time;
  logic [8:0]           addr;
  lcfs_pkg::span_t      sp_in;
  logic [2:0]           r_in, c_in, f_in;
  logic                 scan_oor, scan_last;

  assign busy_out  = out_valid && out_stall;
  assign in_stall  = (state != ST_IDLE) || (busy_out && func == lcfs_pkg::FUNC_SCAN);
  assign accept    = in_valid && !in_stall;
  assign addr      = {f, c, r};
  assign last_cell = (!span.span_r || r == LAST) && (!span.span_c || c == LAST)
                     && (!span.span_f || f == LAST);
  assign sp_in     = lcfs_pkg::func_span(func);
  assign r_in      = sp_in.span_r ? 3'd0 : row;
  assign c_in      = sp_in.span_c ? 3'd0 : column;
  assign f_in      = sp_in.span_f ? 3'd0 : floor;
  assign coord_ok  = (32'(r_in) < SIDE) && (32'(c_in) < SIDE) && (32'(f_in) < SIDE);
  assign expired   = rd_lit && !rd_never && (now_ms > rd_time);
  assign scan_oor  = accept && (func == lcfs_pkg::FUNC_SCAN) && !(32'(floor) < SIDE);
  assign scan_last = (state == ST_CHK) && (r == LAST) && (c == LAST);

  lcfs_store #(.TIME_BITS(TIME_BITS)) u_store (
    .clk(clk), .rst(rst),
    .wr_en(state == ST_SET), .wr_addr(addr), .wr_lit(on_q), .wr_never(forever_q),
    .wr_time(forever_q ? '0 : deadline),
    .clr_en(state == ST_CHK && expired),
    .rd_addr(addr), .rd_lit(rd_lit), .rd_never(rd_never), .rd_time(rd_time)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      now_ms    <= '0;
      out_valid <= 1'b0;
    end else begin
      out_valid <= scan_oor || scan_last || (out_valid && out_stall);
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            on_q <= led_on; forever_q <= no_expiry;
            deadline <= now_ms + duration[TIME_BITS-1:0];
            pat <= '0;
            if (func == lcfs_pkg::FUNC_TICK) begin
              now_ms <= now_ms + 1'b1;
            end else if (func == lcfs_pkg::FUNC_SCAN) begin
              r <= 3'd0; c <= 3'd0; f <= floor;
              span <= '{span_r: 1'b1, span_c: 1'b1, span_f: 1'b0};
              if (32'(floor) < SIDE) begin
                state <= ST_RD;
              end else begin
                floor_pattern <= '0;
                floor_select  <= '0;
              end
            end else if (func < lcfs_pkg::FUNC_TICK) begin
              r <= r_in; c <= c_in; f <= f_in;
              span <= sp_in;
              if (coord_ok) state <= ST_SET;
            end
          end
        end
        ST_SET: begin
          if (last_cell) state <= ST_IDLE;
          else if (span.span_r && r != LAST) r <= r + 1'b1;
          else begin
            if (span.span_r) r <= 3'd0;
            if (span.span_c && c != LAST) c <= c + 1'b1;
            else begin
              if (span.span_c) c <= 3'd0;
              f <= f + 1'b1;
            end
          end
        end
        ST_RD: state <= ST_CHK;
        ST_CHK: begin
          pat[{c, r}] <= rd_lit && !expired;
          if (r == LAST && c == LAST) begin
            floor_pattern <= pat | (64'(rd_lit && !expired) << {c, r});
            floor_select  <= 8'(1) << f;
            state         <= ST_IDLE;
          end else begin
            state <= ST_RD;
            if (r == LAST) begin r <= 3'd0; c <= c + 1'b1; end
            else r <= r + 1'b1;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  a_sel_onehot: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ($onehot(floor_select) || floor_select == 8'd0))
    else $error("floor select not one-hot");
  a_busy_stall: assert property (@(posedge clk) disable iff (rst)
    state != ST_IDLE |-> in_stall) else $error("accepting while busy");
  a_tick: assert property (@(posedge clk) disable iff (rst)
    (accept && func == lcfs_pkg::FUNC_TICK) |=> now_ms == $past(now_ms) + 1'b1)
    else $error("tick lost");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> out_valid && $stable(floor_pattern))
    else $error("stalled result changed");

endmodule
